// ===== sv/lxfr_pkg.sv =====
// Shared types and constants for the sync/length framed receiver.
// No dependencies; imported by every module of the block but the payload store.
package lxfr_pkg;

  // receive phase of the frame parser
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } lxfr_phase_t;

  // result sequencer states
  typedef enum logic [1:0] {
    EM_IDLE  = 2'd0,
    EM_FETCH = 2'd1,
    EM_LOAD  = 2'd2
  } lxfr_emit_state_t;

  // frame_status codes
  localparam logic [2:0] FS_PAYLOAD  = 3'd0;
  localparam logic [2:0] FS_EMPTY    = 3'd1;
  localparam logic [2:0] FS_BAD_SUM  = 3'd2;
  localparam logic [2:0] FS_TOO_LONG = 3'd3;
  localparam logic [2:0] FS_BAD_CMD  = 3'd4;

  // configuration register indices
  localparam logic [1:0] CFG_SYNC  = 2'd0;
  localparam logic [1:0] CFG_BASE  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [7:0] SYNC_RESET  = 8'hAA;
  localparam logic [7:0] BASE_RESET  = 8'h30;
  localparam logic [7:0] COUNT_RESET = 8'd31;

  localparam logic [1:0] HDR_LAST = 2'd3;  // header is 4 bytes, positions 0..3

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] command_base;
    logic [7:0] command_count;
  } lxfr_cfg_t;

  // frame-end request from parser to result sequencer
  typedef struct packed {
    logic       valid;
    logic [2:0] status;
    logic [7:0] idx;
    logic [7:0] len;
  } lxfr_verdict_t;

endpackage

// ===== sv/lxfr_mem.sv =====
// Payload store: single write port, single registered read port.
// Depends on nothing; used by the top level.
module lxfr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lxfr_parse.sv =====
// Frame parser: header collection, payload write into the store, checksum
// and frame-end verdict. Depends on lxfr_pkg.
module lxfr_parse import lxfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 16,
  parameter int AW          = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  input  lxfr_cfg_t     cfg,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          at_check,
  output lxfr_verdict_t verdict
);

  localparam logic [7:0] MAXB = 8'(MAX_PAYLOAD);

  lxfr_phase_t phase, phase_next;
  logic [7:0]  cnt, cnt_next;
  logic        sync_ok, sync_ok_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  running_xor, running_xor_next;

  logic [7:0] cnt_inc;
  logic [1:0] hpos;
  logic [7:0] idx;

  assign cnt_inc = cnt + 8'd1;
  assign hpos    = (cnt > 8'd3) ? 2'd0 : cnt[1:0];
  assign idx     = held_command - cfg.command_base;

  // next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        PH_PAYLOAD: begin
          if (cnt_inc >= held_length) phase_next = PH_CHECK;
        end
        PH_CHECK: begin
          phase_next = PH_HEADER;
        end
        default: begin
          phase_next = PH_HEADER;
          if (hpos == HDR_LAST && sync_ok) begin
            phase_next = (rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECK;
          end
        end
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    cnt_next          = cnt;
    sync_ok_next      = sync_ok;
    held_command_next = held_command;
    held_length_next  = held_length;
    running_xor_next  = running_xor;
    wr_en             = 1'b0;
    wr_addr           = cnt[AW-1:0];
    wr_data           = rx_byte;
    verdict           = '0;
    unique case (phase)
      PH_PAYLOAD: begin
        // over-long frames are consumed but never stored
        wr_en            = take && (held_length <= MAXB) && (cnt < MAXB);
        running_xor_next = running_xor ^ rx_byte;
        cnt_next         = (cnt_inc >= held_length) ? 8'd0 : cnt_inc;
      end
      PH_CHECK: begin
        cnt_next       = 8'd0;
        verdict.valid  = take;
        verdict.idx    = idx;
        verdict.len    = held_length;
        if (held_length > MAXB)            verdict.status = FS_TOO_LONG;
        else if (rx_byte != running_xor)   verdict.status = FS_BAD_SUM;
        else if (idx >= cfg.command_count) verdict.status = FS_BAD_CMD;
        else if (held_length == 8'd0)      verdict.status = FS_EMPTY;
        else                               verdict.status = FS_PAYLOAD;
      end
      default: begin
        if (hpos == 2'd0) begin
          sync_ok_next     = (rx_byte == cfg.sync_value);
          running_xor_next = rx_byte;
        end else begin
          running_xor_next = running_xor ^ rx_byte;
          if (hpos == 2'd2) held_command_next = rx_byte;
          if (hpos == HDR_LAST) held_length_next = rx_byte;
        end
        cnt_next = (hpos == HDR_LAST) ? 8'd0 : {6'd0, hpos} + 8'd1;
      end
    endcase
  end

  assign at_check = (phase == PH_CHECK);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      cnt          <= 8'd0;
      sync_ok      <= 1'b0;
      held_command <= 8'd0;
      held_length  <= 8'd0;
      running_xor  <= 8'd0;
    end else begin
      phase <= phase_next;
      if (take) begin
        cnt          <= cnt_next;
        sync_ok      <= sync_ok_next;
        held_command <= held_command_next;
        held_length  <= held_length_next;
        running_xor  <= running_xor_next;
      end
    end
  end

endmodule

// ===== sv/lxfr_emit.sv =====
// Result sequencer: turns a frame-end request into one status result or a
// run of payload results read back from the store. Depends on lxfr_pkg.
module lxfr_emit import lxfr_pkg::*; #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  lxfr_verdict_t verdict,
  input  logic [7:0]    rd_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output logic          busy,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [2:0]    frame_status,
  output logic [7:0]    command_index,
  output logic [7:0]    payload_byte,
  output logic [5:0]    byte_position,
  output logic [7:0]    payload_length,
  output logic          last_of_frame
);

  lxfr_emit_state_t state, state_next;
  logic [AW-1:0] pos;
  logic [7:0]    fr_idx;
  logic [7:0]    fr_len;
  logic          last;
  logic          load_status;
  logic          load_data;

  assign last = (8'(pos) + 8'd1) == fr_len;

  always_comb begin
    state_next = state;
    unique case (state)
      EM_IDLE: begin
        if (verdict.valid && verdict.status == FS_PAYLOAD) state_next = EM_FETCH;
      end
      EM_FETCH: begin
        if (!out_valid) state_next = EM_LOAD;
      end
      EM_LOAD: begin
        state_next = last ? EM_IDLE : EM_FETCH;
      end
      default: state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    rd_en       = (state == EM_FETCH) && !out_valid;
    rd_addr     = pos;
    busy        = (state != EM_IDLE);
    load_status = (state == EM_IDLE) && verdict.valid && (verdict.status != FS_PAYLOAD);
    load_data   = (state == EM_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= EM_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_status || load_data) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == EM_IDLE && verdict.valid) begin
      pos    <= '0;
      fr_idx <= verdict.idx;
      fr_len <= verdict.len;
    end else if (load_data && !last) begin
      pos <= pos + 1'b1;
    end
    if (load_status) begin
      frame_status   <= verdict.status;
      command_index  <= verdict.idx;
      payload_byte   <= 8'd0;
      byte_position  <= 6'd0;
      payload_length <= verdict.len;
      last_of_frame  <= 1'b1;
    end else if (load_data) begin
      frame_status   <= FS_PAYLOAD;
      command_index  <= fr_idx;
      payload_byte   <= rd_data;
      byte_position  <= 6'(pos);
      payload_length <= fr_len;
      last_of_frame  <= last;
    end
  end

  // a result is only ever loaded into an empty output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_status || load_data) |-> !out_valid)
    else $error("output register overwritten");

  // frame-end requests arrive only while idle
  a_req_when_idle: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> (state == EM_IDLE))
    else $error("frame-end request while draining");

  // payload reads stay inside the frame
  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (8'(pos) < fr_len))
    else $error("payload read past frame length");

  // read data is consumed the cycle after the read
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == EM_LOAD))
    else $error("read not followed by load");

endmodule

// ===== sv/sync_length_xor_frame_receiver_unit.sv =====
// A status result appears the cycle after the checksum byte is taken; the
// first payload result follows a store read and an output load. Bytes are
// taken one per cycle while in_stall is low; payload results drain one at a
// time (store read, output load, hand-off), input stalled meanwhile.
// Reset: synchronous; clears control state and config to defaults. The payload
// store is not cleared: only entries written in the current frame are read.
module sync_length_xor_frame_receiver_unit import lxfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] frame_status,
  output logic [7:0] command_index,
  output logic [7:0] payload_byte,
  output logic [5:0] byte_position,
  output logic [7:0] payload_length,
  output logic       last_of_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  lxfr_cfg_t     cfg;
  lxfr_verdict_t verdict;
  logic          take;
  logic          at_check;
  logic          em_busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value    <= SYNC_RESET;
      cfg.command_base  <= BASE_RESET;
      cfg.command_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SYNC:  cfg.sync_value    <= cfg_data;
        CFG_BASE:  cfg.command_base  <= cfg_data;
        CFG_COUNT: cfg.command_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off while draining, or at the checksum byte if a result still waits
  assign in_stall = em_busy || (at_check && out_valid);
  assign take     = in_valid && !in_stall;

  lxfr_parse #(.MAX_PAYLOAD(MAX_PAYLOAD), .AW(AW)) u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .at_check (at_check),
    .verdict  (verdict)
  );

  lxfr_mem #(.DEPTH(MAX_PAYLOAD), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lxfr_emit #(.AW(AW)) u_emit (
    .clk            (clk),
    .rst            (rst),
    .verdict        (verdict),
    .rd_data        (rd_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .busy           (em_busy),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .frame_status   (frame_status),
    .command_index  (command_index),
    .payload_byte   (payload_byte),
    .byte_position  (byte_position),
    .payload_length (payload_length),
    .last_of_frame  (last_of_frame)
  );

endmodule
